### sv/lcdf_pkg.sv
// Shared types, constants and the byte-wise CRC-32 update for the
// length-prefixed CRC-32 frame deframer. No dependencies.
`default_nettype none

package lcdf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned HDR_IDX_W = 3;
  localparam int unsigned LEN_BYTES = 4;

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [WORD_W-1:0]    HDR_LEN      = WORD_W'(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);
  localparam logic [HDR_IDX_W-1:0] LEN_LAST_IDX = HDR_IDX_W'(LEN_BYTES - 1);

  // One result transaction as held in the output register.
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              has_byte;
    logic              frame_end;
    logic              crc_ok;
    logic              length_bad;
  } result_t;

  // Reflected CRC-32, one byte folded in, eight shift steps.
  function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/lcdf_ifs.sv
// Valid/ready channel interfaces of the frame deframer: received bytes in,
// payload and frame status out. Depends on lcdf_pkg.
`default_nettype none

interface lcdf_in_if;
  logic                             valid;
  logic                             ready;
  logic [lcdf_pkg::BYTE_W-1:0]      rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcdf_out_if;
  logic                             valid;
  logic                             ready;
  logic [lcdf_pkg::BYTE_W-1:0]      payload_byte;
  logic                             has_byte;
  logic                             frame_end;
  logic                             crc_ok;
  logic                             length_bad;

  modport source (output valid, output payload_byte, output has_byte, output frame_end,
                  output crc_ok, output length_bad, input ready);
  modport sink   (input valid, input payload_byte, input has_byte, input frame_end,
                  input crc_ok, input length_bad, output ready);
endinterface

`default_nettype wire

### sv/length_crc32_packet_deframer.sv
// Length-prefixed frame deframer with CRC-32 payload check.
// An accepted byte is held in the input register; its result goes into the result
// register. Throughput: one byte per cycle unless a result stalls at the output,
// set by the combinational CRC byte update.
// Header bytes other than the last give no result and never wait on the output side.
// Reset (rst_n low, synchronous) empties both stages and returns to header parsing.
// Depends on lcdf_pkg and lcdf_ifs.
`default_nettype none

module length_crc32_packet_deframer (
  input  wire         clk,
  input  wire         rst_n,
  lcdf_in_if.sink     in_ch,
  lcdf_out_if.source  out_ch
);

  // input register
  logic                            s1_v_r;
  logic [lcdf_pkg::BYTE_W-1:0]     s1_byte_r;

  // frame state
  logic                            in_payload_r, in_payload_nxt;
  logic [lcdf_pkg::HDR_IDX_W-1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [lcdf_pkg::WORD_W-1:0]     frame_len_r, frame_len_nxt;
  logic [lcdf_pkg::WORD_W-1:0]     exp_crc_r, exp_crc_nxt;
  logic [lcdf_pkg::WORD_W-1:0]     run_crc_r, run_crc_nxt;
  logic [lcdf_pkg::WORD_W-1:0]     bytes_left_r, bytes_left_nxt;

  // result register
  logic                            out_v_r;
  lcdf_pkg::result_t               res_r, res_nxt;

  logic                            emit;
  logic                            s1_go;
  logic [lcdf_pkg::WORD_W-1:0]     crc_upd;
  logic [lcdf_pkg::WORD_W-1:0]     len_shift;
  logic [lcdf_pkg::WORD_W-1:0]     crc_shift;
  logic                            len_short;

  assign crc_upd   = lcdf_pkg::crc32_byte(run_crc_r, s1_byte_r);
  assign len_shift = {frame_len_r[lcdf_pkg::WORD_W-lcdf_pkg::BYTE_W-1:0], s1_byte_r};
  assign crc_shift = {exp_crc_r[lcdf_pkg::WORD_W-lcdf_pkg::BYTE_W-1:0], s1_byte_r};
  assign len_short = frame_len_r < lcdf_pkg::HDR_LEN;

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_idx_nxt    = hdr_idx_r;
    frame_len_nxt  = frame_len_r;
    exp_crc_nxt    = exp_crc_r;
    run_crc_nxt    = run_crc_r;
    bytes_left_nxt = bytes_left_r;
    emit           = 1'b0;
    res_nxt        = '0;
    if (in_payload_r) begin
      emit                 = 1'b1;
      bytes_left_nxt       = bytes_left_r - 1'b1;
      run_crc_nxt          = crc_upd;
      res_nxt.payload_byte = s1_byte_r;
      res_nxt.has_byte     = 1'b1;
      if (bytes_left_r == {{(lcdf_pkg::WORD_W-1){1'b0}}, 1'b1}) begin
        res_nxt.frame_end = 1'b1;
        res_nxt.crc_ok    = (crc_upd ^ lcdf_pkg::CRC_INIT) == exp_crc_r;
        in_payload_nxt    = 1'b0;
        hdr_idx_nxt       = '0;
        run_crc_nxt       = lcdf_pkg::CRC_INIT;
      end
    end else begin
      if (hdr_idx_r <= lcdf_pkg::LEN_LAST_IDX) begin
        frame_len_nxt = len_shift;
      end else begin
        exp_crc_nxt = crc_shift;
      end
      if (hdr_idx_r != lcdf_pkg::HDR_LAST_IDX) begin
        hdr_idx_nxt = hdr_idx_r + 1'b1;
      end else begin
        // header complete: length bytes already in, CRC gets its last byte now
        hdr_idx_nxt = '0;
        run_crc_nxt = lcdf_pkg::CRC_INIT;
        if (frame_len_r <= lcdf_pkg::HDR_LEN) begin
          emit               = 1'b1;
          res_nxt.frame_end  = 1'b1;
          res_nxt.length_bad = len_short;
          res_nxt.crc_ok     = !len_short && (crc_shift == '0);
        end else begin
          bytes_left_nxt = frame_len_r - lcdf_pkg::HDR_LEN;
          in_payload_nxt = 1'b1;
        end
      end
    end
  end

  // advance stage 1 when it holds no result-causing byte or the output slot frees up
  assign s1_go       = s1_v_r && (!emit || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      in_payload_r <= 1'b0;
      hdr_idx_r    <= '0;
      run_crc_r    <= lcdf_pkg::CRC_INIT;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s1_go) begin
        in_payload_r <= in_payload_nxt;
        hdr_idx_r    <= hdr_idx_nxt;
        run_crc_r    <= run_crc_nxt;
      end
      if (s1_go && emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (s1_go) begin
      frame_len_r  <= frame_len_nxt;
      exp_crc_r    <= exp_crc_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
    if (s1_go && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.has_byte     = res_r.has_byte;
  assign out_ch.frame_end    = res_r.frame_end;
  assign out_ch.crc_ok       = res_r.crc_ok;
  assign out_ch.length_bad   = res_r.length_bad;

endmodule

`default_nettype wire

### sv/lcdf_checker.sv
// Port-level checks on the deframer's result channel, bound to the top level.
// Depends on lcdf_pkg and length_crc32_packet_deframer.
`default_nettype none

module lcdf_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [lcdf_pkg::BYTE_W-1:0]       out_payload_byte,
  input wire                              out_has_byte,
  input wire                              out_frame_end,
  input wire                              out_crc_ok,
  input wire                              out_length_bad
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  // status flags only ever ride on a frame end
  a_flags_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> !out_crc_ok && !out_length_bad)
    else $error("status flag set outside frame end");

  // a result without a payload byte is a header-only frame end with a zero byte
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_frame_end && (out_payload_byte == '0))
    else $error("byte-less result that is not a header-only frame end");

  // a length error ends the frame at the header, never with a byte or a good CRC
  a_len_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_bad |-> !out_has_byte && !out_crc_ok)
    else $error("length error combined with payload byte or good CRC");

endmodule

bind length_crc32_packet_deframer lcdf_checker u_lcdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_payload_byte (out_ch.payload_byte),
  .out_has_byte     (out_ch.has_byte),
  .out_frame_end    (out_ch.frame_end),
  .out_crc_ok       (out_ch.crc_ok),
  .out_length_bad   (out_ch.length_bad)
);

`default_nettype wire
